[design/bounded_min_heap_reservoir_sampler_core_macros.svh]
// Assertion macros for the reservoir sampler core.
// No dependencies; included by the top level.
`ifndef BOUNDED_MIN_HEAP_RESERVOIR_SAMPLER_CORE_MACROS_SVH
`define BOUNDED_MIN_HEAP_RESERVOIR_SAMPLER_CORE_MACROS_SVH
// assert that an implication holds on every clock edge outside reset
`define BMH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assert an implication that also holds during reset
`define BMH_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[design/bmhrs_pkg.sv]
// Shared constants and types for the reservoir sampler core.
// No dependencies.
package bmhrs_pkg;
  localparam int CAPACITY_DEF  = 16;
  localparam int RAND_BITS_DEF = 16;
  localparam int VAL_W = 32;
  localparam int LIM_W = 5;
  localparam int SLOT_W = 4;
  localparam int MAX_OUT = 16;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_READ  = 1'b1;
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic signed [VAL_W-1:0] wt;
  } entry_t;
endpackage

[design/bounded_min_heap_reservoir_sampler_core.sv]
// Bounded reservoir sampler held in a min-heap keyed by signed weight; needs bmhrs_pkg.
// Offer to acknowledge: a plain insert sifts up; a rejected draw runs multiply and decision;
// pop-and-replace sifts down, then up; one heap address and one compare a cycle.
// Readout: after the S_RDRD fetch, one result per cycle while out_ready does not stall it.
// One transaction at a time: in_ready returns the cycle after the last result is loaded.
// Reset (synchronous, rst_n low): sample empty, seen count zero, limit 16, no result held.
`include "bounded_min_heap_reservoir_sampler_core_macros.svh"
module bounded_min_heap_reservoir_sampler_core #(
  parameter int CAPACITY = bmhrs_pkg::CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [bmhrs_pkg::LIM_W-1:0] cfg_wdata,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_command,
  input  logic signed [31:0] in_item_value,
  input  logic signed [31:0] in_item_weight,
  input  logic [15:0] in_rand_fraction,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_kind,
  output logic out_accepted,
  output logic signed [31:0] out_entry_value,
  output logic signed [31:0] out_entry_weight,
  output logic [3:0] out_slot,
  output logic out_last
);
  import bmhrs_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;  // child index width, never wraps

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL0  = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_POPRD = 4'd4;
  localparam logic [3:0] S_DNL   = 4'd5;
  localparam logic [3:0] S_DNR   = 4'd6;
  localparam logic [3:0] S_DNCMP = 4'd7;
  localparam logic [3:0] S_UPRD  = 4'd8;
  localparam logic [3:0] S_UPCMP = 4'd9;
  localparam logic [3:0] S_RDRD  = 4'd10;
  localparam logic [3:0] S_RDOUT = 4'd11;
  localparam logic [3:0] S_ACK   = 4'd12;

  logic [3:0] state_r, state_nxt;

  // heap memory: one address per cycle, registered read data (old data on a write)
  entry_t        mem [CAPACITY];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  entry_t        mem_wd;
  entry_t        mem_rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_rd_r <= mem[mem_addr];
  end

  logic [LIM_W-1:0] limit_r;
  logic [CW-1:0]    size_r, size_nxt;
  logic [31:0]      seen_r, seen_nxt;
  entry_t           ins_r, ins_nxt;     // offered item, held until its insert starts
  entry_t           item_r, item_nxt;   // entry being sifted (the hole's value)
  entry_t           best_r, best_nxt;   // smaller of hole entry and left child
  logic [AW-1:0]    hole_r, hole_nxt;
  logic             bleft_r, bleft_nxt; // left child beat the hole entry
  logic             rvalid_r, rvalid_nxt;
  logic [15:0]      rnd_r, rnd_nxt;
  logic [47:0]      prod_r, prod_nxt;
  logic             acc_r, acc_nxt;
  logic [CW-1:0]    rd_i_r, rd_i_nxt;
  logic [CW-1:0]    rd_n_r, rd_n_nxt;

  // result register
  logic              ov_r, ov_nxt;
  logic [1:0]        ok_r, ok_nxt;
  logic              oa_r, oa_nxt;
  entry_t            oe_r, oe_nxt;
  logic [SLOT_W-1:0] os_r, os_nxt;
  logic              ol_r, ol_nxt;
  logic              out_free;

  // effective limit: clamp the register to the heap capacity
  logic [CW-1:0] lim;
  assign lim = (8'(limit_r) > 8'(CAPACITY)) ? CW'(CAPACITY) : CW'(limit_r);

  // shared multiply unit: one 16 x 16 partial product per cycle, in S_MUL0 then S_MUL1
  logic [32:0] seen_p1;
  logic [15:0] mul_b;
  logic [31:0] mul_p;
  assign seen_p1 = {1'b0, seen_r} + 33'd1;
  assign mul_b = (state_r == S_MUL0) ? seen_p1[15:0] : seen_p1[31:16];
  assign mul_p = 32'(rnd_r) * 32'(mul_b);

  // draw = (rand * (seen + 1)) >> RAND_BITS; bit 32 of seen + 1 adds rand << 32
  logic [48:0] full_prod;
  logic [48:0] draw;
  assign full_prod = {1'b0, prod_r} + (seen_p1[32] ? {1'b0, rnd_r, 32'd0} : 49'd0);
  assign draw = full_prod >> RAND_BITS_DEF;

  // shared signed compare, operands steered by state
  logic signed [31:0] cmp_a, cmp_b;
  logic cmp_lt;
  assign cmp_a = (state_r == S_UPCMP) ? item_r.wt : mem_rd_r.wt;
  assign cmp_b = (state_r == S_UPCMP) ? mem_rd_r.wt :
                 (state_r == S_DNR)   ? item_r.wt : best_r.wt;
  assign cmp_lt = cmp_a < cmp_b;

  logic [XW-1:0] lchild, rchild, size_x;
  logic [AW-1:0] parent;
  assign lchild = {1'b0, hole_r, 1'b0} + XW'(1);
  assign rchild = {1'b0, hole_r, 1'b0} + XW'(2);
  assign size_x = XW'(size_r);
  assign parent = (hole_r - AW'(1)) >> 1;

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !ov_r || out_ready;

  always_comb begin
    state_nxt = state_r; size_nxt = size_r; seen_nxt = seen_r; ins_nxt = ins_r;
    item_nxt = item_r; best_nxt = best_r; hole_nxt = hole_r; bleft_nxt = bleft_r;
    rvalid_nxt = rvalid_r; rnd_nxt = rnd_r; prod_nxt = prod_r; acc_nxt = acc_r;
    rd_i_nxt = rd_i_r; rd_n_nxt = rd_n_r;
    ov_nxt = ov_r && !out_ready; ok_nxt = ok_r; oa_nxt = oa_r; oe_nxt = oe_r;
    os_nxt = os_r; ol_nxt = ol_r;
    mem_we = 1'b0; mem_addr = hole_r; mem_wd = item_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rnd_nxt = in_rand_fraction;
          acc_nxt = 1'b0;
          ins_nxt.val = in_item_value;
          ins_nxt.wt = in_item_weight;
          if (in_command == CMD_READ) begin
            // readout: report at most MAX_OUT slots in array order
            rd_n_nxt = (8'(size_r) > 8'(MAX_OUT)) ? CW'(MAX_OUT) : size_r;
            rd_i_nxt = '0;
            state_nxt = S_RDRD;
          end else begin
            // count the offer (saturating) before any draw uses it
            if (seen_r != 32'hFFFF_FFFF) seen_nxt = seen_r + 32'd1;
            if (size_r < lim) begin
              // room left: insert at the tail and sift up
              acc_nxt = 1'b1;
              item_nxt.val = in_item_value;
              item_nxt.wt = in_item_weight;
              hole_nxt = AW'(size_r);
              size_nxt = size_r + CW'(1);
              state_nxt = S_UPRD;
            end else begin
              state_nxt = S_MUL0;
            end
          end
        end
      end
      S_MUL0: begin
        prod_nxt = {16'd0, mul_p};
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        prod_nxt = prod_r + {mul_p, 16'd0};
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (draw < 49'(lim) && size_r != '0) begin
          // replace: fetch the tail entry, it moves to the root
          acc_nxt = 1'b1;
          size_nxt = size_r - CW'(1);
          mem_addr = AW'(size_r - CW'(1));
          state_nxt = S_POPRD;
        end else begin
          state_nxt = S_ACK;
        end
      end
      S_POPRD: begin
        item_nxt = mem_rd_r;
        hole_nxt = '0;
        state_nxt = S_DNL;
      end
      S_DNL: begin
        if (lchild < size_x) begin
          mem_addr = lchild[AW-1:0];
          state_nxt = S_DNR;
        end else begin
          // no children: drop the sifted entry into the hole, start the insert
          mem_we = 1'b1;
          item_nxt = ins_r;
          hole_nxt = AW'(size_r);
          size_nxt = size_r + CW'(1);
          state_nxt = S_UPRD;
        end
      end
      S_DNR: begin
        // left child is on the read port; keep the smaller, fetch the right child
        if (cmp_lt) begin
          best_nxt = mem_rd_r;
          bleft_nxt = 1'b1;
        end else begin
          best_nxt = item_r;
          bleft_nxt = 1'b0;
        end
        rvalid_nxt = (rchild < size_x);
        if (rchild < size_x) mem_addr = rchild[AW-1:0];
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        mem_we = 1'b1;
        if (rvalid_r && cmp_lt) begin
          // right child is smallest: move it up into the hole
          mem_wd = mem_rd_r;
          hole_nxt = rchild[AW-1:0];
          state_nxt = S_DNL;
        end else if (bleft_r) begin
          mem_wd = best_r;
          hole_nxt = lchild[AW-1:0];
          state_nxt = S_DNL;
        end else begin
          // heap order restored: settle the entry, start the insert at the tail
          item_nxt = ins_r;
          hole_nxt = AW'(size_r);
          size_nxt = size_r + CW'(1);
          state_nxt = S_UPRD;
        end
      end
      S_UPRD: begin
        if (hole_r == '0) begin
          mem_we = 1'b1;
          state_nxt = S_ACK;
        end else begin
          mem_addr = parent;
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          // parent is larger: pull it down and advance the hole
          mem_wd = mem_rd_r;
          hole_nxt = parent;
          state_nxt = S_UPRD;
        end else begin
          state_nxt = S_ACK;
        end
      end
      S_RDRD: begin
        mem_addr = AW'(rd_i_r);
        state_nxt = S_RDOUT;
      end
      S_RDOUT: begin
        // hold the address while the result register is busy
        mem_addr = AW'(rd_i_r);
        if (out_free) begin
          ov_nxt = 1'b1;
          oa_nxt = 1'b0;
          os_nxt = SLOT_W'(rd_i_r);
          if (rd_n_r == '0) begin
            ok_nxt = KIND_EMPTY;
            oe_nxt = '0;
            ol_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ok_nxt = KIND_ENTRY;
            oe_nxt = mem_rd_r;
            ol_nxt = (rd_i_r + CW'(1) == rd_n_r);
            rd_i_nxt = rd_i_r + CW'(1);
            mem_addr = AW'(rd_i_r + CW'(1));
            if (rd_i_r + CW'(1) == rd_n_r) state_nxt = S_IDLE;
          end
        end
      end
      S_ACK: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          ok_nxt = KIND_ACK;
          oa_nxt = acc_r;
          oe_nxt = '0;
          os_nxt = '0;
          ol_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      size_r  <= '0;
      seen_r  <= '0;
      limit_r <= LIMIT_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      seen_r  <= seen_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
    end
  end

  // datapath registers: meaningful only under the sequencer, no reset needed
  always_ff @(posedge clk) begin
    ins_r <= ins_nxt; item_r <= item_nxt; best_r <= best_nxt; hole_r <= hole_nxt;
    bleft_r <= bleft_nxt; rvalid_r <= rvalid_nxt; rnd_r <= rnd_nxt; prod_r <= prod_nxt;
    acc_r <= acc_nxt; rd_i_r <= rd_i_nxt; rd_n_r <= rd_n_nxt;
    ok_r <= ok_nxt; oa_r <= oa_nxt; oe_r <= oe_nxt; os_r <= os_nxt; ol_r <= ol_nxt;
  end

  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_accepted = oa_r;
  assign out_entry_value = oe_r.val;
  assign out_entry_weight = oe_r.wt;
  assign out_slot = os_r;
  assign out_last = ol_r;

  `BMH_ASSERT(a_size_bound, clk, rst_n, (size_r <= CW'(CAPACITY)), "sample size over capacity")
  `BMH_ASSERT(a_busy_not_ready, clk, rst_n, (state_r != S_IDLE) |-> !in_ready, "ready while busy")
  `BMH_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_kind) && $stable(out_last)), "result dropped before accept")
  `BMH_ASSERT_ALWAYS(a_reset_idle, clk, (!rst_n) |=> (state_r == S_IDLE && !out_valid), "reset")
endmodule

[bench/tb_bounded_min_heap_reservoir_sampler_core.sv]
// Testbench for the bounded min-heap reservoir sampler core: random and directed
// offers and readouts checked against a heap-based sample predictor.
// Depends on bmhrs_pkg and the core RTL.
module tb_bounded_min_heap_reservoir_sampler_core;
  import bmhrs_pkg::*;

  typedef struct packed {
    logic        cmd;
    logic [31:0] val;
    logic [31:0] wt;
    logic [15:0] frac;
  } offer_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        acc;
    logic [31:0] val;
    logic [31:0] wt;
    logic [3:0]  slot;
    logic        last;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [LIM_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = 1'b0;
  logic signed [31:0] in_item_value = '0;
  logic signed [31:0] in_item_weight = '0;
  logic [15:0] in_rand_fraction = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  logic out_accepted;
  logic signed [31:0] out_entry_value;
  logic signed [31:0] out_entry_weight;
  logic [3:0] out_slot;
  logic out_last;

  bounded_min_heap_reservoir_sampler_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_item_value(in_item_value), .in_item_weight(in_item_weight),
    .in_rand_fraction(in_rand_fraction),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_accepted(out_accepted), .out_entry_value(out_entry_value),
    .out_entry_weight(out_entry_weight), .out_slot(out_slot), .out_last(out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: a shadow of the sample heap and its counters.
  logic [31:0] sample_val [CAPACITY_DEF];
  logic [31:0] sample_wt [CAPACITY_DEF];
  int unsigned sample_count;
  logic [31:0] seen_count;
  logic [LIM_W-1:0] limit_reg;

  offer_t pending_items[$];
  report_t expected_reports[$];
  int mismatches = 0;
  int reports_seen = 0;
  int offers_taken = 0;
  int readouts_taken = 0;
  int cycle_count = 0;
  bit long_hold = 0;

  function automatic bit weight_below(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic void swap_entries(int a, int b);
    logic [31:0] t;
    t = sample_val[a]; sample_val[a] = sample_val[b]; sample_val[b] = t;
    t = sample_wt[a]; sample_wt[a] = sample_wt[b]; sample_wt[b] = t;
  endfunction

  function automatic void heap_add(logic [31:0] v, logic [31:0] w);
    int i;
    int p;
    if (sample_count >= CAPACITY_DEF) return;
    i = sample_count;
    sample_val[i] = v;
    sample_wt[i] = w;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!weight_below(sample_wt[i], sample_wt[p])) break;
      swap_entries(i, p);
      i = p;
    end
    sample_count++;
  endfunction

  function automatic void heap_drop_min();
    int i;
    int l;
    int r;
    int m;
    if (sample_count == 0) return;
    sample_count--;
    sample_val[0] = sample_val[sample_count];
    sample_wt[0] = sample_wt[sample_count];
    i = 0;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      m = i;
      if (l < sample_count && weight_below(sample_wt[l], sample_wt[m])) m = l;
      if (r < sample_count && weight_below(sample_wt[r], sample_wt[m])) m = r;
      if (m == i) break;
      swap_entries(i, m);
      i = m;
    end
  endfunction

  // Work out the reports one transaction causes and queue them.
  function automatic void predict_sample(offer_t it);
    int unsigned lim;
    int unsigned n;
    logic [63:0] draw;
    report_t rep;
    bit taken;
    lim = (limit_reg < CAPACITY_DEF) ? limit_reg : CAPACITY_DEF;
    if (it.cmd == CMD_READ) begin
      n = (sample_count < MAX_OUT) ? sample_count : MAX_OUT;
      if (n == 0) begin
        rep = '{KIND_EMPTY, 1'b0, 32'd0, 32'd0, 4'd0, 1'b1};
        expected_reports.push_back(rep);
      end
      for (int i = 0; i < n; i++) begin
        rep = '{KIND_ENTRY, 1'b0, sample_val[i], sample_wt[i], 4'(i), i + 1 == n};
        expected_reports.push_back(rep);
      end
      return;
    end
    taken = 0;
    if (seen_count != 32'hFFFF_FFFF) seen_count++;
    if (sample_count < lim) begin
      heap_add(it.val, it.wt);
      taken = 1;
    end else begin
      draw = (64'(it.frac) * (64'(seen_count) + 64'd1)) >> RAND_BITS_DEF;
      if (draw < lim && sample_count > 0) begin
        heap_drop_min();
        heap_add(it.val, it.wt);
        taken = 1;
      end
    end
    rep = '{KIND_ACK, taken, 32'd0, 32'd0, 4'd0, 1'b1};
    expected_reports.push_back(rep);
  endfunction

  // Driver: offer queued items with a random gap between them.
  int send_gap = 0;
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      predict_sample(offer_t'({in_command, in_item_value, in_item_weight,
                               in_rand_fraction}));
      if (in_command == CMD_READ) readouts_taken++;
      else offers_taken++;
    end
    if (!in_valid || in_ready) begin
      // The current transaction is done (or none is held): pick the next one.
      if (send_gap > 0 || pending_items.size() == 0) begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end else begin
        in_valid <= 1'b1;
        {in_command, in_item_value, in_item_weight, in_rand_fraction}
          <= pending_items.pop_front();
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end
    end
  end

  // Monitor: compare each accepted report with the oldest expectation.
  int stall = 0;
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (out_valid && out_ready) begin
      got = '{out_kind, out_accepted, out_entry_value, out_entry_weight, out_slot,
              out_last};
      reports_seen++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report %p", got);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    end
    // Hold ready low while stalled or during the long back-pressure stretch.
    if (long_hold || stall > 0) begin
      out_ready <= 1'b0;
      if (stall > 0) stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("timeout: %0d reports still expected", expected_reports.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic offer_t make_offer(logic [31:0] v, logic [31:0] w, logic [15:0] f);
    return '{CMD_OFFER, v, w, f};
  endfunction

  function automatic offer_t make_readout();
    return '{CMD_READ, $urandom(), $urandom(), 16'($urandom())};
  endfunction

  // Wait for the queue to drain and the block to settle before a register write.
  // Sample between edges so the driver's updates of this cycle are already visible.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIM_W-1:0] lim);
    cfg_we <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_reg = lim;
  endtask

  // Random phase: mostly offers with frequent readouts; weights often clustered.
  task automatic random_phase(int count);
    logic [31:0] w;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        pending_items.push_back(make_readout());
      end else begin
        case ($urandom_range(0, 2))
          0: w = $urandom_range(0, 7) - 4;
          1: w = $urandom();
          default: w = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom())};
        endcase
        pending_items.push_back(make_offer($urandom(), w, 16'($urandom())));
      end
    end
  endtask

  initial begin
    logic [LIM_W-1:0] lims [5];
    lims = '{5'd1, 5'd0, 5'd31, 5'd5, 5'd16};
    sample_count = 0;
    seen_count = 0;
    limit_reg = LIMIT_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty readout, field extremes, fill to capacity, then replacement.
    pending_items.push_back(make_readout());
    pending_items.push_back(make_offer(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF));
    pending_items.push_back(make_offer(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000));
    pending_items.push_back(make_offer(32'hFFFF_FFFF, 32'h0000_0000, 16'h8000));
    pending_items.push_back(make_offer(32'h0000_0000, 32'hFFFF_FFFF, 16'h0001));
    for (int i = 0; i < 12; i++)
      pending_items.push_back(make_offer($urandom(), 32'(12 - i), 16'($urandom())));
    pending_items.push_back(make_readout());
    pending_items.push_back(make_offer(32'h1234_5678, 32'h0000_0100, 16'h0000));
    pending_items.push_back(make_offer(32'h5555_AAAA, 32'hAAAA_5555, 16'hFFFF));
    pending_items.push_back(make_readout());

    // Long receiver hold while offers keep flowing, so the block backs up.
    long_hold = 1;
    repeat (300) @(posedge clk);
    long_hold = 0;
    wait_idle();

    // Sweep limits: small, zero (never accepts), above capacity (clamped), a
    // lowered limit below the current size, then back to the reset value.
    foreach (lims[k]) begin
      write_limit(lims[k]);
      pending_items.push_back(make_readout());
      random_phase(65);
      pending_items.push_back(make_readout());
      wait_idle();
    end

    wait_idle();
    $display("covered %0d offers and %0d readouts, %0d reports checked, limits 0..31",
             offers_taken, readouts_taken, reports_seen);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end
endmodule
